[rtl/core/obo_pkg.sv]
package obo_pkg;

  // Unit vector scale, Q1.14.
  localparam logic [15:0] UNIT_ONE = 16'd16384;

  // Reset value of the height gap limit, 2.2 m in Q8.8.
  localparam logic [15:0] LIMIT_RESET = 16'd563;

  // One root bit per square root stage: sqrt of (s << 28) with s below 2^32.
  localparam int SQRT_STEPS = 30;

  // One quotient bit per divider stage.
  localparam int DIV_STEPS = 16;

  // Normalizer latency: magnitude, sum of squares, root stages, dividend
  // setup, quotient stages and the final sign and clamp stage.
  localparam int NORM_LAT = 1 + 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;

endpackage

[rtl/core/oriented_box_overlap_test_core.sv]
// Throughput: one word per cycle; the heading normalizers resolve one root
// bit and one quotient bit per stage, so every stage is busy each cycle.
// A stall on the output holds the whole pipeline in place.
// Reset (rst, synchronous) empties the pipeline and sets the height gap
// limit to 2.2 m.
module oriented_box_overlap_test_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // offset_x, offset_z, height_diff, a_heading_x, a_heading_z, a_half_width,
  // a_half_length, b_heading_x, b_heading_z, b_half_width, b_half_length
  input  logic [199:0] s_tdata,
  // height_known
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // overlap, then zero fill
  output logic [7:0]   m_tdata
);
  import obo_pkg::*;

  typedef struct packed {
    logic signed [23:0] dx;
    logic signed [23:0] dz;
    logic [15:0]        aw;
    logic [15:0]        al;
    logic [15:0]        bw;
    logic [15:0]        bl;
    logic               hsep;
  } side_t;

  logic        en;
  logic [15:0] height_gap_limit;

  // The whole pipeline advances together unless the output word is held.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      height_gap_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      height_gap_limit <= cfg_wdata;
    end
  end

  // Input field unpacking and the height gap check.
  logic signed [23:0] in_hd;
  logic [23:0]        hd_abs;
  side_t              in_side;

  always_comb begin
    in_hd        = signed'(s_tdata[71:48]);
    hd_abs       = in_hd[23] ? 24'(-in_hd) : 24'(in_hd);
    in_side.dx   = signed'(s_tdata[23:0]);
    in_side.dz   = signed'(s_tdata[47:24]);
    in_side.aw   = s_tdata[119:104];
    in_side.al   = s_tdata[135:120];
    in_side.bw   = s_tdata[183:168];
    in_side.bl   = s_tdata[199:184];
    in_side.hsep = s_tuser && (hd_abs > {8'd0, height_gap_limit});
  end

  // Heading normalizers.
  logic signed [15:0] afx, afz, bfx, bfz;

  obo_norm u_norm_a (
    .clk (clk),
    .en  (en),
    .hx  (signed'(s_tdata[87:72])),
    .hz  (signed'(s_tdata[103:88])),
    .ux  (afx),
    .uz  (afz)
  );

  obo_norm u_norm_b (
    .clk (clk),
    .en  (en),
    .hx  (signed'(s_tdata[151:136])),
    .hz  (signed'(s_tdata[167:152])),
    .ux  (bfx),
    .uz  (bfz)
  );

  // Side fields and valid bits travel beside the normalizers.
  side_t side [0:NORM_LAT-1];
  logic  vld  [0:NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORM_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < NORM_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int i = 1; i < NORM_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Dot products of the unit vectors and projections of the offset.
  side_t              sd_l;
  logic signed [31:0] eax, eaz, ebx, ebz;
  logic signed [40:0] edx, edz, fax, faz, fbx, fbz;

  always_comb begin
    sd_l = side[NORM_LAT-1];
    eax  = 32'(afx);
    eaz  = 32'(afz);
    ebx  = 32'(bfx);
    ebz  = 32'(bfz);
    edx  = 41'(sd_l.dx);
    edz  = 41'(sd_l.dz);
    fax  = 41'(afx);
    faz  = 41'(afz);
    fbx  = 41'(bfx);
    fbz  = 41'(bfz);
  end

  logic               v1;
  side_t              s1;
  logic signed [31:0] d_p, d_q, d_c, d_d;
  logic signed [40:0] pr [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vld[NORM_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= sd_l;
      d_p   <= eax * eax + eaz * eaz;
      d_q   <= ebx * ebx + ebz * ebz;
      d_c   <= eax * ebx + eaz * ebz;
      d_d   <= eax * ebz - eaz * ebx;
      pr[0] <= edx * fax + edz * faz;
      pr[1] <= edz * fax - edx * faz;
      pr[2] <= edx * fbx + edz * fbz;
      pr[3] <= edz * fbx - edx * fbz;
    end
  end

  // Extents times absolute dot products.
  logic [30:0] ap, aq, ac, ad;

  always_comb begin
    ap = 31'(d_p);
    aq = 31'(d_q);
    ac = d_c[31] ? 31'(-d_c) : 31'(d_c);
    ad = d_d[31] ? 31'(-d_d) : 31'(d_d);
  end

  logic        v2, hsep2;
  logic [46:0] rt [0:11];
  logic [39:0] pa [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsep2  <= s1.hsep;
      rt[0]  <= 47'(s1.al) * 47'(ap);
      rt[1]  <= 47'(s1.bl) * 47'(ac);
      rt[2]  <= 47'(s1.bw) * 47'(ad);
      rt[3]  <= 47'(s1.aw) * 47'(ap);
      rt[4]  <= 47'(s1.bl) * 47'(ad);
      rt[5]  <= 47'(s1.bw) * 47'(ac);
      rt[6]  <= 47'(s1.al) * 47'(ac);
      rt[7]  <= 47'(s1.aw) * 47'(ad);
      rt[8]  <= 47'(s1.bl) * 47'(aq);
      rt[9]  <= 47'(s1.al) * 47'(ad);
      rt[10] <= 47'(s1.aw) * 47'(ac);
      rt[11] <= 47'(s1.bw) * 47'(aq);
      for (int k = 0; k < 4; k++) begin
        pa[k] <= pr[k][40] ? 40'(-pr[k]) : 40'(pr[k]);
      end
    end
  end

  // Radius sums per axis; the projection moves to the radius scale.
  logic        v3, hsep3;
  logic [48:0] rad [0:3];
  logic [53:0] prj [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsep3  <= hsep2;
      rad[0] <= 49'(rt[0]) + 49'(rt[1]) + 49'(rt[2]);
      rad[1] <= 49'(rt[3]) + 49'(rt[4]) + 49'(rt[5]);
      rad[2] <= 49'(rt[6]) + 49'(rt[7]) + 49'(rt[8]);
      rad[3] <= 49'(rt[9]) + 49'(rt[10]) + 49'(rt[11]);
      for (int k = 0; k < 4; k++) begin
        prj[k] <= {pa[k], 14'd0};
      end
    end
  end

  // Any separating axis or a large height gap means no overlap.
  logic sep_any;

  always_comb begin
    sep_any = hsep3;
    for (int k = 0; k < 4; k++) begin
      if (prj[k] >= 54'(rad[k])) begin
        sep_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, !sep_any};
    end
  end

endmodule

[rtl/core/obo_norm.sv]
module obo_norm (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] hx,
  input  logic signed [15:0] hz,
  output logic signed [15:0] ux,
  output logic signed [15:0] uz
);
  import obo_pkg::*;

  // Magnitude stage.
  logic [15:0] mag_x, mag_z;
  logic        neg_x, neg_z;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x <= hx[15] ? 16'(-hx) : 16'(hx);
      mag_z <= hz[15] ? 16'(-hz) : 16'(hz);
      neg_x <= hx[15];
      neg_z <= hz[15];
    end
  end

  // Square root pipeline; entry 0 holds the sum of squares.
  logic [31:0] sq_src  [0:SQRT_STEPS];
  logic [31:0] sq_rem  [0:SQRT_STEPS];
  logic [29:0] sq_root [0:SQRT_STEPS];
  logic [15:0] sq_mx   [0:SQRT_STEPS];
  logic [15:0] sq_mz   [0:SQRT_STEPS];
  logic        sq_nx   [0:SQRT_STEPS];
  logic        sq_nz   [0:SQRT_STEPS];
  logic        sq_zero [0:SQRT_STEPS];
  logic [31:0] sum_sq;

  assign sum_sq = 32'(mag_x) * 32'(mag_x) + 32'(mag_z) * 32'(mag_z);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_src[0]  <= sum_sq;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_mx[0]   <= mag_x;
      sq_mz[0]   <= mag_z;
      sq_nx[0]   <= neg_x;
      sq_nz[0]   <= neg_z;
      sq_zero[0] <= (sum_sq == '0);
    end
  end

  // Each stage brings down two radicand bits and settles one root bit.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [33:0] trial, tsub;

    always_comb begin
      trial = {sq_rem[j], sq_src[j][31:30]};
      tsub  = {2'b00, sq_root[j], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= tsub) begin
          sq_rem[j+1]  <= 32'(trial - tsub);
          sq_root[j+1] <= {sq_root[j][28:0], 1'b1};
        end else begin
          sq_rem[j+1]  <= 32'(trial);
          sq_root[j+1] <= {sq_root[j][28:0], 1'b0};
        end
        sq_src[j+1]  <= {sq_src[j][29:0], 2'b00};
        sq_mx[j+1]   <= sq_mx[j];
        sq_mz[j+1]   <= sq_mz[j];
        sq_nx[j+1]   <= sq_nx[j];
        sq_nz[j+1]   <= sq_nz[j];
        sq_zero[j+1] <= sq_zero[j];
      end
    end
  end

  // Divider pipeline; entry 0 holds the rounded dividend split into the
  // leading part, already below the divisor, and the bits still to come.
  logic [29:0] dv_len  [0:DIV_STEPS];
  logic [30:0] dv_rx   [0:DIV_STEPS];
  logic [30:0] dv_rz   [0:DIV_STEPS];
  logic [15:0] dv_lx   [0:DIV_STEPS];
  logic [15:0] dv_lz   [0:DIV_STEPS];
  logic [15:0] dv_qx   [0:DIV_STEPS];
  logic [15:0] dv_qz   [0:DIV_STEPS];
  logic        dv_nx   [0:DIV_STEPS];
  logic        dv_nz   [0:DIV_STEPS];
  logic        dv_zero [0:DIV_STEPS];
  logic [43:0] num_x, num_z;

  always_comb begin
    num_x = {sq_mx[SQRT_STEPS], 28'd0} + 44'(sq_root[SQRT_STEPS] >> 1);
    num_z = {sq_mz[SQRT_STEPS], 28'd0} + 44'(sq_root[SQRT_STEPS] >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0]  <= sq_root[SQRT_STEPS];
      dv_rx[0]   <= 31'(num_x[43:16]);
      dv_rz[0]   <= 31'(num_z[43:16]);
      dv_lx[0]   <= num_x[15:0];
      dv_lz[0]   <= num_z[15:0];
      dv_qx[0]   <= '0;
      dv_qz[0]   <= '0;
      dv_nx[0]   <= sq_nx[SQRT_STEPS];
      dv_nz[0]   <= sq_nz[SQRT_STEPS];
      dv_zero[0] <= sq_zero[SQRT_STEPS];
    end
  end

  // Restoring division, both components against the same length.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0] tx, tz, dl;

    always_comb begin
      tx = {dv_rx[k], dv_lx[k][15]};
      tz = {dv_rz[k], dv_lz[k][15]};
      dl = {2'b00, dv_len[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (tx >= dl) begin
          dv_rx[k+1] <= 31'(tx - dl);
          dv_qx[k+1] <= {dv_qx[k][14:0], 1'b1};
        end else begin
          dv_rx[k+1] <= 31'(tx);
          dv_qx[k+1] <= {dv_qx[k][14:0], 1'b0};
        end
        if (tz >= dl) begin
          dv_rz[k+1] <= 31'(tz - dl);
          dv_qz[k+1] <= {dv_qz[k][14:0], 1'b1};
        end else begin
          dv_rz[k+1] <= 31'(tz);
          dv_qz[k+1] <= {dv_qz[k][14:0], 1'b0};
        end
        dv_lx[k+1]   <= {dv_lx[k][14:0], 1'b0};
        dv_lz[k+1]   <= {dv_lz[k][14:0], 1'b0};
        dv_len[k+1]  <= dv_len[k];
        dv_nx[k+1]   <= dv_nx[k];
        dv_nz[k+1]   <= dv_nz[k];
        dv_zero[k+1] <= dv_zero[k];
      end
    end
  end

  // Clamp to one, restore signs, and map a zero heading to the x axis.
  logic [15:0] qcx, qcz;

  always_comb begin
    qcx = (dv_qx[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : dv_qx[DIV_STEPS];
    qcz = (dv_qz[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : dv_qz[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_zero[DIV_STEPS]) begin
        ux <= signed'(UNIT_ONE);
        uz <= '0;
      end else begin
        ux <= dv_nx[DIV_STEPS] ? -signed'(qcx) : signed'(qcx);
        uz <= dv_nz[DIV_STEPS] ? -signed'(qcz) : signed'(qcz);
      end
    end
  end

endmodule

[verif/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obo_pkg::*;

  // Pipeline depth plus some slack, used for drain pauses.
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 420;

  typedef struct packed {
    logic signed [23:0] off_x;
    logic signed [23:0] off_z;
    logic signed [23:0] hgt_diff;
    logic               hgt_known;
    logic signed [15:0] a_hx;
    logic signed [15:0] a_hz;
    logic [15:0]        a_hw;
    logic [15:0]        a_hl;
    logic signed [15:0] b_hx;
    logic signed [15:0] b_hz;
    logic [15:0]        b_hw;
    logic [15:0]        b_hl;
  } box_pair_t;

  // One directed row: a pair and, where obvious, its expected overlap.
  typedef struct {
    box_pair_t pair;
    int        known_result; // -1: take the prediction
  } pair_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [199:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  logic [15:0]  gap_limit = LIMIT_RESET;
  logic         overlap_q[$];
  int           mismatches = 0;
  int           words_in = 0;
  int           words_out = 0;
  int           overlaps_seen = 0;
  int           idle_cycles = 0;
  bit           pace_rx = 1'b0;
  pair_row_t    rows[$];

  oriented_box_overlap_test_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Integer square root, one result bit per step.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rounded Q1.14 component of a heading, clamped to one.
  function automatic longint unit_part(longint c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? -c : c;
    q = ((mag << 28) + len / 2) / len;
    if (q > 64'(UNIT_ONE)) q = 64'(UNIT_ONE);
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void unit_heading(input longint x, input longint z,
                                       output longint ux, output longint uz);
    longint unsigned s;
    longint unsigned len;
    s = longint'(x * x) + longint'(z * z);
    if (s == 0) begin
      ux = longint'(UNIT_ONE);
      uz = 0;
    end else begin
      len = int_root(s << 28);
      ux = unit_part(x, len);
      uz = unit_part(z, len);
    end
  endfunction

  function automatic longint unsigned abs_dot(longint ax, longint az, longint bx, longint bz);
    longint d;
    d = ax * bx + az * bz;
    return (d < 0) ? -d : d;
  endfunction

  // Separating axis test on the four box axes, with the height early out.
  function automatic logic boxes_overlap(box_pair_t p, logic [15:0] lim);
    longint afx, afz, bfx, bfz, arx, arz, brx, brz, dx, dz, hd, x, z;
    longint ax[4], az[4];
    longint unsigned rad, proj;
    dx = longint'(p.off_x);
    dz = longint'(p.off_z);
    hd = longint'(p.hgt_diff);
    if (p.hgt_known && ((hd < 0) ? -hd : hd) > longint'(lim)) return 1'b0;
    unit_heading(longint'(p.a_hx), longint'(p.a_hz), afx, afz);
    unit_heading(longint'(p.b_hx), longint'(p.b_hz), bfx, bfz);
    arx = -afz; arz = afx;
    brx = -bfz; brz = bfx;
    ax = '{afx, arx, bfx, brx};
    az = '{afz, arz, bfz, brz};
    for (int k = 0; k < 4; k++) begin
      x = ax[k];
      z = az[k];
      rad = longint'(p.a_hl) * abs_dot(afx, afz, x, z)
          + longint'(p.a_hw) * abs_dot(arx, arz, x, z)
          + longint'(p.b_hl) * abs_dot(bfx, bfz, x, z)
          + longint'(p.b_hw) * abs_dot(brx, brz, x, z);
      proj = abs_dot(dx, dz, x, z) << 14;
      if (proj >= rad) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [199:0] pack_pair(box_pair_t p);
    return {p.b_hl, p.b_hw, p.b_hz, p.b_hx, p.a_hl, p.a_hw, p.a_hz, p.a_hx,
            p.hgt_diff, p.off_z, p.off_x};
  endfunction

  // Rebuild a pair from the bus fields, lowest tdata field first.
  function automatic box_pair_t unpack_pair(logic [199:0] d, logic u);
    box_pair_t p;
    p.off_x = d[23:0]; p.off_z = d[47:24]; p.hgt_diff = d[71:48]; p.hgt_known = u;
    p.a_hx = d[87:72]; p.a_hz = d[103:88]; p.a_hw = d[119:104]; p.a_hl = d[135:120];
    p.b_hx = d[151:136]; p.b_hz = d[167:152]; p.b_hw = d[183:168]; p.b_hl = d[199:184];
    return p;
  endfunction

  function automatic box_pair_t make_pair(int ox, int oz, int hd, bit hk,
                                          int ahx, int ahz, int ahw, int ahl,
                                          int bhx, int bhz, int bhw, int bhl);
    box_pair_t p;
    p.off_x = 24'(ox); p.off_z = 24'(oz); p.hgt_diff = 24'(hd); p.hgt_known = hk;
    p.a_hx = 16'(ahx); p.a_hz = 16'(ahz); p.a_hw = 16'(ahw); p.a_hl = 16'(ahl);
    p.b_hx = 16'(bhx); p.b_hz = 16'(bhz); p.b_hw = 16'(bhw); p.b_hl = 16'(bhl);
    return p;
  endfunction

  function automatic int signed_in(int span);
    int r;
    r = $urandom_range(2 * span, 0);
    return r - span;
  endfunction

  // Random pair: mostly nearby boxes of car size, some fully random words.
  function automatic box_pair_t random_pair(logic [15:0] lim);
    box_pair_t p;
    int mode;
    logic [223:0] raw;
    mode = $urandom_range(9, 0);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[200:0];
    if (mode < 7) begin
      p.off_x = 24'(signed_in(1500));
      p.off_z = 24'(signed_in(1500));
      p.a_hw = 16'($urandom_range(600, 0));
      p.a_hl = 16'($urandom_range(1200, 0));
      p.b_hw = 16'($urandom_range(600, 0));
      p.b_hl = 16'($urandom_range(1200, 0));
      p.hgt_diff = 24'(signed_in(int'(lim) + 300));
      if (mode == 0) begin
        p.a_hx = 16'(signed_in(3));
        p.a_hz = 16'(signed_in(3));
      end
    end else if (mode == 7) begin
      p.off_x = 24'(signed_in(40000));
      p.off_z = 24'(signed_in(40000));
    end
    return p;
  endfunction

  // Scoreboard: record each accepted pair, check each result word.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        overlap_q = {overlap_q, boxes_overlap(unpack_pair(s_tdata, s_tuser), gap_limit)};
        words_in <= words_in + 1;
      end
      if (m_tvalid && m_tready) begin
        words_out <= words_out + 1;
        if (m_tdata[0]) overlaps_seen <= overlaps_seen + 1;
        if (overlap_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          if (m_tdata !== {7'd0, overlap_q[0]}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected overlap %b, got word %h",
                       words_out, overlap_q[0], m_tdata);
          end
          void'(overlap_q.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", overlap_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: alternates between rare and frequent random stalls.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (pace_rx) m_tready <= ($urandom_range(3, 0) != 0);
    else m_tready <= ($urandom_range(63, 0) < 61) || (($urandom & 32'h7) == 0);
  end

  always @(negedge clk) begin
    if ($urandom_range(300, 0) == 0) pace_rx <= ~pace_rx;
  end

  task automatic add_row(box_pair_t p, int r);
    pair_row_t row;
    row.pair = p;
    row.known_result = r;
    rows = {rows, row};
  endtask

  task automatic send_pair(box_pair_t p);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= pack_pair(p);
    s_tuser <= p.hgt_known;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_sender(0);
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    gap_limit <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic in bursts, most of them followed by a gap.
  task automatic random_burst_run(int n);
    int left;
    left = $urandom_range(30, 1);
    for (int i = 0; i < n; i++) begin
      send_pair(random_pair(gap_limit));
      left--;
      if (left == 0) begin
        left = $urandom_range(30, 1);
        if ($urandom_range(2, 0) != 0) pause_sender($urandom_range(12, 0));
      end
    end
  endtask

  initial begin
    logic [15:0] limits[4];
    // Directed rows; the height limit is at its reset value here.
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(make_pair(0, 0, 0, 0, 1, 0, 256, 256, 1, 0, 256, 256), 1);
    add_row(make_pair(0, 0, 564, 1, 1, 0, 256, 256, 1, 0, 256, 256), 0);
    add_row(make_pair(0, 0, 563, 1, 1, 0, 256, 256, 1, 0, 256, 256), 1);
    add_row(make_pair(0, 0, -564, 1, 1, 0, 256, 256, 1, 0, 256, 256), 0);
    add_row(make_pair(0, 0, -8388608, 1, 1, 0, 256, 256, 1, 0, 256, 256), 0);
    add_row(make_pair(0, 0, 8388607, 0, 1, 0, 256, 256, 1, 0, 256, 256), 1);
    add_row(make_pair(0, 0, 0, 1, 0, 0, 256, 256, 0, 0, 256, 256), 1);
    // Boxes just touching along x count as separated.
    add_row(make_pair(512, 0, 0, 0, 1, 0, 256, 256, 1, 0, 256, 256), 0);
    add_row(make_pair(8388607, 8388607, 0, 0, 5, 7, 10, 10, -3, 9, 10, 10), 0);
    add_row(make_pair(-8388608, -8388608, 0, 0, 5, 7, 10, 10, -3, 9, 10, 10), 0);
    add_row(make_pair(0, 0, 0, 0, 32767, 32767, 65535, 65535,
                      -32768, -32768, 65535, 65535), 1);
    add_row(make_pair(-8388608, 8388607, 0, 1, -32768, 0, 65535, 65535,
                      0, 32767, 65535, 65535), -1);
    add_row(make_pair(300, -200, 100, 1, -32768, -32768, 400, 900,
                      32767, -1, 300, 800), -1);
    add_row(make_pair(1000, 700, -50, 1, 3, -4, 200, 1000, 1, 1, 250, 600), -1);
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].known_result >= 0 &&
          boxes_overlap(rows[i].pair, gap_limit) != rows[i].known_result[0]) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with the hand value", i);
      end
      send_pair(rows[i].pair);
    end
    drain_results();

    limits = '{16'd0, 16'hFFFF, 16'($urandom), LIMIT_RESET};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      random_burst_run(RAND_PER_PHASE / 2);
      // Hold the sender until the pipeline is empty once per phase.
      pause_sender(0);
      while (overlap_q.size() != 0) @(posedge clk);
      random_burst_run(RAND_PER_PHASE / 2);
      drain_results();
    end

    $display("%0d pairs sent, %0d results checked, %0d overlapping.",
             words_in, words_out, overlaps_seen);
    $display("Directed rows at the reset limit, then four written limits with bursty traffic.");
    if (mismatches == 0 && overlap_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, overlap_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[oriented_box_overlap_test_core.f]
rtl/core/obo_pkg.sv
rtl/core/obo_norm.sv
rtl/core/oriented_box_overlap_test_core.sv
verif/tb.sv
